/* design/cbsf_pkg.sv */
// shared constants, types and config register codes of the cluster-bounded fir
`timescale 1ns / 1ps
`default_nettype none

package cbsf_pkg;

    localparam int MAX_TAPS       = 12;
    localparam int SAMPLE_BITS    = 24;
    localparam int CLUSTER_BITS   = 16;
    localparam int COEF_BITS      = 16;
    localparam int VALUE_BITS     = 32;
    localparam int FRAC_BITS      = 14;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int TAPS_CFG_BITS  = 4;
    localparam int TAPS_RESET     = 10;
    localparam int COEF_REGS      = 3;

    localparam int WIN_DEPTH  = 2 * MAX_TAPS - 1;
    localparam int IDX_W      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
    localparam int LEN_W      = $clog2(MAX_TAPS + 1);
    localparam int OFF_W      = IDX_W + 2;
    localparam int COEFS_PER_REG = CFG_DATA_BITS / COEF_BITS;

    // coefficient after optional negation, product and tree sum
    localparam int ECOEF_W    = COEF_BITS + 1;
    localparam int PROD_W     = SAMPLE_BITS + ECOEF_W;
    localparam int TREE_LVLS  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int TREE_PAD   = 1 << TREE_LVLS;
    localparam int SUM_W      = PROD_W + TREE_LVLS;
    localparam int SHIFT_W    = SUM_W - FRAC_BITS;
    localparam int EXT_W      = (SHIFT_W > VALUE_BITS) ? SHIFT_W : VALUE_BITS;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [CLUSTER_BITS-1:0] NO_CLUSTER = '1;
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COEF_LOW  = 3'd0,
        CFG_COEF_MID  = 3'd1,
        CFG_COEF_HIGH = 3'd2,
        CFG_TAPS      = 3'd3,
        CFG_NEGATE    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  sample;
        logic signed [CLUSTER_BITS-1:0] cluster;
    } win_entry_t;

    // per-request controls broadcast to every tap cell
    typedef struct packed {
        logic [LEN_W-1:0] d;
        logic [IDX_W-1:0] hi;
        logic [LEN_W-1:0] len;
        logic             negate;
        win_entry_t       center;
    } tap_ctl_t;

    typedef struct packed {
        logic ok;
        logic last;
    } side_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         ok;
        logic                         last;
    } result_t;

endpackage

`default_nettype wire

/* design/cbsf_cell.sv */
// one window stage with its tap: neighbor select, cluster check, coefficient and product
`timescale 1ns / 1ps
`default_nettype none

module cbsf_cell
    import cbsf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       shift_en,
    input  wire win_entry_t                 shift_in,
    output      win_entry_t                 entry,
    input  wire win_entry_t                 window [WIN_DEPTH],
    input  wire tap_ctl_t                   ctl,
    input  wire logic [IDX_W-1:0]           tap_pos,
    input  wire logic signed [COEF_BITS-1:0] coef,
    output      logic signed [PROD_W-1:0]   product
);

    win_entry_t                  entry_reg;
    logic signed [OFF_W-1:0]     off_raw;
    logic signed [OFF_W-1:0]     hi_s;
    logic [IDX_W-1:0]            off;
    win_entry_t                  nb;
    logic                        left;
    logic [IDX_W-1:0]            abs_pos;
    logic                        active;
    logic signed [SAMPLE_BITS-1:0] smp_next;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic signed [ECOEF_W-1:0]   coef_next;
    logic signed [ECOEF_W-1:0]   coef_reg;
    logic signed [PROD_W-1:0]    product_reg;

    // window stage, moves one place older on every accepted item
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= shift_in;
        end
    end

    assign entry = entry_reg;

    always_comb
    begin
        // neighbor offset, clamped to the scan ends
        off_raw = OFF_W'(ctl.d) + OFF_W'(MAX_TAPS - 1) - OFF_W'(tap_pos);
        hi_s    = OFF_W'(ctl.hi);
        if (off_raw[OFF_W-1])
        begin
            off = '0;
        end
        else if (off_raw > hi_s)
        begin
            off = ctl.hi;
        end
        else
        begin
            off = off_raw[IDX_W-1:0];
        end
        nb = window[off];
        // other cluster: take the center sample
        smp_next = (nb.cluster == ctl.center.cluster) ? nb.sample : ctl.center.sample;

        left    = tap_pos < IDX_W'(MAX_TAPS - 1);
        abs_pos = left ? IDX_W'(MAX_TAPS - 1) - tap_pos : tap_pos - IDX_W'(MAX_TAPS - 1);
        active  = abs_pos < IDX_W'(ctl.len);
        if (!active)
        begin
            coef_next = '0;
        end
        else if (left && ctl.negate)
        begin
            coef_next = -ECOEF_W'(coef);
        end
        else
        begin
            coef_next = ECOEF_W'(coef);
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg     <= smp_next;
        coef_reg    <= coef_next;
        product_reg <= smp_reg * coef_reg;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

/* design/cbsf_sum.sv */
// registered adder tree over the tap products, then shift and saturate
`timescale 1ns / 1ps
`default_nettype none

module cbsf_sum
    import cbsf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire side_t                    in_side,
    input  wire logic signed [PROD_W-1:0] products [WIN_DEPTH],
    output      logic                     out_valid,
    output      result_t                  out_res
);

    logic signed [SUM_W-1:0]   leaf [TREE_PAD];
    logic signed [SUM_W-1:0]   node_reg [1:TREE_PAD-1];
    logic                      vld_reg [TREE_LVLS];
    side_t                     side_reg [TREE_LVLS];
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [EXT_W-1:0]   sh_ext;
    logic [EXT_W-VALUE_BITS:0] sat_hi;
    result_t                   res_next;
    logic                      out_valid_reg;
    result_t                   out_res_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TREE_PAD; gi++)
        begin : g_leaf
            if (gi < WIN_DEPTH)
            begin : g_used
                assign leaf[gi] = SUM_W'(products[gi]);
            end
            else
            begin : g_pad
                assign leaf[gi] = '0;
            end
        end

        // heap order: node n adds nodes 2n and 2n+1, the bottom row adds leaves
        for (gi = 1; gi < TREE_PAD; gi++)
        begin : g_node
            if (2 * gi >= TREE_PAD)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node_reg[gi] <= leaf[2 * gi - TREE_PAD] + leaf[2 * gi + 1 - TREE_PAD];
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node_reg[gi] <= node_reg[2 * gi] + node_reg[2 * gi + 1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TREE_LVLS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < TREE_LVLS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int i = 1; i < TREE_LVLS; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_comb
    begin
        // arithmetic shift rounds toward minus infinity
        shifted = node_reg[1][SUM_W-1:FRAC_BITS];
        sh_ext  = EXT_W'(shifted);
        sat_hi  = sh_ext[EXT_W-1:VALUE_BITS-1];
        res_next.ok   = side_reg[TREE_LVLS-1].ok;
        res_next.last = side_reg[TREE_LVLS-1].last;
        if (!side_reg[TREE_LVLS-1].ok)
        begin
            res_next.value = '0;
        end
        else if (!(&sat_hi) && (|sat_hi))
        begin
            res_next.value = sh_ext[EXT_W-1] ? VALUE_MIN : VALUE_MAX;
        end
        else
        begin
            res_next.value = sh_ext[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= vld_reg[TREE_LVLS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

/* design/cbsf_fifo.sv */
// result queue between the fixed-latency pipeline and the output channel
`timescale 1ns / 1ps
`default_nettype none

module cbsf_fifo
    import cbsf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    output      logic    rd_valid,
    input  wire logic    rd_stall,
    output      result_t rd_data
);

    result_t           storage_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              rd_take;

    assign rd_valid = (fill_reg != '0);
    assign rd_take  = rd_valid && !rd_stall;
    assign rd_data  = storage_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg + FILL_W'(wr_en) - FILL_W'(rd_take);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            storage_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

/* design/cluster_bounded_symmetric_fir.sv */
// top level: config registers, scan control, cell chain, adder tree and result queue
//
//   channel   direction  handshake               payload
//   item      in         item_valid/item_stall   sample, cluster_id, last
//   result    out        result_valid/result_stall value, valid_res, last_out
//   cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one item per cycle while item_stall is low; a result passes the job register, the cell
//   registers, the adder tree and the result queue; an item with last set holds the item
//   channel until the scan's pending results issue, one per cycle with a free slot
// the result queue holds 16 results; up to 16 requests may be in flight, more
//   output stall than that holds the item channel
// reset returns registers to their reset values and starts an empty scan; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module cluster_bounded_symmetric_fir
    import cbsf_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output      logic                         item_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]  sample,
    input  wire logic signed [CLUSTER_BITS-1:0] cluster_id,
    input  wire logic                         last,
    output      logic                         result_valid,
    input  wire logic                         result_stall,
    output      logic signed [VALUE_BITS-1:0] value,
    output      logic                         valid_res,
    output      logic                         last_out,
    input  wire logic                         cfg_valid,
    output      logic                         cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]     cfg_data
);

    // configuration
    logic [CFG_DATA_BITS-1:0] coef_reg [COEF_REGS];
    logic [TAPS_CFG_BITS-1:0] taps_reg;
    logic                     negate_reg;
    logic [LEN_W-1:0]         len;

    // scan control
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  cnt_new;
    logic              enough;
    logic              job_valid_reg;
    logic              job_valid_next;
    logic [LEN_W-1:0]  job_d_reg;
    logic [LEN_W-1:0]  job_d_next;
    logic [IDX_W-1:0]  job_hi_reg;
    logic [IDX_W-1:0]  job_hi_next;
    logic              job_last_reg;
    logic              job_last_next;
    logic              accept;
    logic              issue;
    logic              more;
    logic              credit_ok;
    logic [FILL_W-1:0] outstanding_reg;
    logic [FILL_W-1:0] outstanding_next;
    logic              take;

    // datapath
    win_entry_t              new_entry;
    win_entry_t              window [WIN_DEPTH];
    win_entry_t              center;
    tap_ctl_t                ctl;
    side_t                   side_issue;
    logic                    vld_a_reg;
    side_t                   side_a_reg;
    logic                    vld_b_reg;
    side_t                   side_b_reg;
    logic signed [PROD_W-1:0] products [WIN_DEPTH];
    logic                    sum_valid;
    result_t                 sum_res;
    result_t                 head;

    // config port: always ready, writes outside the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
            taps_reg   <= TAPS_CFG_BITS'(TAPS_RESET);
            negate_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COEF_LOW:  coef_reg[0] <= cfg_data;
                CFG_COEF_MID:  coef_reg[1] <= cfg_data;
                CFG_COEF_HIGH: coef_reg[2] <= cfg_data;
                CFG_TAPS:      taps_reg    <= cfg_data[TAPS_CFG_BITS-1:0];
                CFG_NEGATE:    negate_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // half window length, zero acts as one and large values as the maximum
    always_comb
    begin
        if (taps_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (taps_reg > TAPS_CFG_BITS'(MAX_TAPS))
        begin
            len = LEN_W'(MAX_TAPS);
        end
        else
        begin
            len = LEN_W'(taps_reg);
        end
    end

    // a request leaves the job register when a queue slot is reserved for it;
    // a closing item keeps it busy until the newest pending point is done
    assign credit_ok  = outstanding_reg < FILL_W'(FIFO_DEPTH);
    assign issue      = job_valid_reg && credit_ok;
    assign more       = job_last_reg && (job_d_reg != '0);
    assign item_stall = job_valid_reg && !(issue && !more);
    assign accept     = item_valid && !item_stall;
    assign take       = result_valid && !result_stall;

    // point count saturates at the window depth: older points are never reached
    assign cnt_new = (count_reg == CNT_W'(WIN_DEPTH)) ? count_reg : CNT_W'(count_reg + 1'b1);
    assign enough  = cnt_new >= CNT_W'(len);

    always_comb
    begin
        count_next     = count_reg;
        job_valid_next = job_valid_reg;
        job_d_next     = job_d_reg;
        job_hi_next    = job_hi_reg;
        job_last_next  = job_last_reg;
        if (accept)
        begin
            job_hi_next   = IDX_W'(cnt_new - 1'b1);
            job_last_next = last;
            if (last)
            begin
                // flush: centers from min(count, L)-1 points back down to the newest
                job_valid_next = 1'b1;
                job_d_next     = (enough ? len : LEN_W'(cnt_new)) - 1'b1;
                count_next     = '0;
            end
            else
            begin
                job_valid_next = enough;
                job_d_next     = len - 1'b1;
                count_next     = cnt_new;
            end
        end
        else if (issue)
        begin
            if (more)
            begin
                job_d_next = job_d_reg - 1'b1;
            end
            else
            begin
                job_valid_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        outstanding_next = outstanding_reg + FILL_W'(issue) - FILL_W'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            job_valid_reg   <= 1'b0;
            outstanding_reg <= '0;
            vld_a_reg       <= 1'b0;
            vld_b_reg       <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            job_valid_reg   <= job_valid_next;
            outstanding_reg <= outstanding_next;
            vld_a_reg       <= issue;
            vld_b_reg       <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        job_d_reg    <= job_d_next;
        job_hi_reg   <= job_hi_next;
        job_last_reg <= job_last_next;
        side_a_reg   <= side_issue;
        side_b_reg   <= side_a_reg;
    end

    // center point of the current request and the controls every cell sees
    assign new_entry.sample  = sample;
    assign new_entry.cluster = cluster_id;
    assign center            = window[IDX_W'(job_d_reg)];

    always_comb
    begin
        ctl.d      = job_d_reg;
        ctl.hi     = job_hi_reg;
        ctl.len    = len;
        ctl.negate = negate_reg;
        ctl.center = center;
        side_issue.ok   = center.cluster != NO_CLUSTER;
        side_issue.last = job_last_reg && (job_d_reg == '0);
    end

    // chain of cells: cell k holds the point k places behind the newest and
    // computes tap k of the window from entry d+(MAX_TAPS-1)-k after clamping
    genvar gk;
    generate
        for (gk = 0; gk < WIN_DEPTH; gk++)
        begin : g_cell
            localparam int ABSJ  = (gk >= MAX_TAPS - 1) ? gk - (MAX_TAPS - 1) : (MAX_TAPS - 1) - gk;
            localparam int CREG  = ABSJ / COEFS_PER_REG;
            localparam int CSLOT = ABSJ % COEFS_PER_REG;
            win_entry_t shift_in;

            if (gk == 0)
            begin : g_head
                assign shift_in = new_entry;
            end
            else
            begin : g_body
                assign shift_in = window[gk-1];
            end

            cbsf_cell u_cell (
                .clk      (clk),
                .shift_en (accept),
                .shift_in (shift_in),
                .entry    (window[gk]),
                .window   (window),
                .ctl      (ctl),
                .tap_pos  (IDX_W'(gk)),
                .coef     ($signed(coef_reg[CREG][CSLOT*COEF_BITS +: COEF_BITS])),
                .product  (products[gk])
            );
        end
    endgenerate

    cbsf_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_b_reg),
        .in_side   (side_b_reg),
        .products  (products),
        .out_valid (sum_valid),
        .out_res   (sum_res)
    );

    cbsf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (sum_valid),
        .wr_data  (sum_res),
        .rd_valid (result_valid),
        .rd_stall (result_stall),
        .rd_data  (head)
    );

    assign value     = head.value;
    assign valid_res = head.ok;
    assign last_out  = head.last;

`ifndef SYNTHESIS
    // reserved queue slots never exceed the queue
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= FILL_W'(FIFO_DEPTH))
        else $error("more requests in flight than queue slots");

    // no new item while a scan flush still has points to do
    a_flush_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && job_last_reg && (job_d_reg != '0)) |-> item_stall)
        else $error("item taken during scan flush");

    // each flush step moves one point toward the newest
    a_flush_step: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && more) |=> (job_valid_reg && (job_d_reg == $past(job_d_reg) - 1'b1)))
        else $error("flush step skipped or repeated a point");

    // a shown result always belongs to a counted request
    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (outstanding_reg != '0))
        else $error("result without a request in flight");

    // a closing item starts a new scan
    a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (count_reg == '0))
        else $error("point count not cleared at end of scan");
`endif

endmodule

`default_nettype wire
